@@ rtl/core/lif_neuron_update_engine_assert.svh @@
// Assertion macros shared by the neuron update engine RTL.
// Depends on nothing; the files that check their own logic include it.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef LIF_NEURON_UPDATE_ENGINE_ASSERT_SVH
`define LIF_NEURON_UPDATE_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define LIF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lif engine: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define LIF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lif engine: next-cycle check failed");

`else

`define LIF_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define LIF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/core/lif_pkg.sv @@
// Shared types, codes and saturation helpers of the neuron update engine.
// Depends on nothing; every RTL module imports it.
`default_nettype none

package lif_pkg;

    // Command codes.
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_INC    = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // Population parameter slots.
    localparam logic [2:0] PS_KS     = 3'd0;
    localparam logic [2:0] PS_MEAN   = 3'd1;
    localparam logic [2:0] PS_SIGMA  = 3'd2;
    localparam logic [2:0] PS_KM     = 3'd3;
    localparam logic [2:0] PS_REST   = 3'd4;
    localparam logic [2:0] PS_THRESH = 3'd5;
    localparam logic [2:0] PS_RESET  = 3'd6;
    localparam logic [2:0] PS_REFR   = 3'd7;
    localparam int PARAM_SLOTS = 8;

    // Default sizes.
    localparam int NEURONS_DEF     = 1024;
    localparam int POPULATIONS_DEF = 4;

    // Membrane value after reset: -65.0 in Q16.16.
    localparam logic signed [31:0] MEMBRANE_RESET_Q = -32'sd4259840;

    // One command beat.
    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         neuron;
        logic [1:0]         population;
        logic [31:0]        tick;
        logic signed [31:0] noise;
        logic signed [31:0] value;
        logic [2:0]         param_select;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic        spike;
        logic [9:0]  spike_neuron;
        logic [31:0] spike_tick;
    } t_result;

    // State of one neuron as held in the store.
    typedef struct packed {
        logic signed [31:0] membrane;
        logic signed [31:0] syn_current;
        logic [31:0]        last_tick;
        logic               has_spiked;
    } t_neuron;

    localparam t_neuron NEURON_RESET = '{
        membrane:    MEMBRANE_RESET_Q,
        syn_current: 32'sd0,
        last_tick:   32'd0,
        has_spiked:  1'b0
    };

    // Clamp a 34-bit signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/lif_serial_mul.sv @@
// Bit-serial signed Q16.16 multiplier: one multiplier bit per cycle,
// floor of the product over 65536, saturated to 32 bits. Uses lif_pkg.
`default_nettype none

module lif_serial_mul
    import lif_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic                    o_done,
    output logic signed [31:0]      o_q
);

`include "lif_neuron_update_engine_assert.svh"

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic signed [31:0] r_a;
    logic [31:0]        r_b;
    logic signed [32:0] r_hi;
    logic [31:0]        r_lo;

    logic signed [33:0] w_part;
    logic signed [33:0] w_sum;
    logic signed [48:0] w_q;

    // Partial product of this step; the top multiplier bit weighs negative.
    always_comb begin
        if (!r_b[0]) begin
            w_part = '0;
        end else if (r_cnt == 5'd31) begin
            w_part = -34'(r_a);
        end else begin
            w_part = 34'(r_a);
        end
        w_sum = 34'(r_hi) + w_part;
    end

    // Control and shift-add datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_hi <= w_sum[33:1];
            r_lo <= {w_sum[0], r_lo[31:1]};
            r_b  <= {1'b0, r_b[31:1]};
        end
    end

    // Drop sixteen fraction bits (floor) and clamp.
    always_comb begin
        w_q = {r_hi, r_lo[31:16]};
        if (w_q > 49'sh7FFFFFFF) begin
            o_q = 32'sh7FFFFFFF;
        end else if (w_q < -49'sh80000000) begin
            o_q = 32'sh80000000;
        end else begin
            o_q = w_q[31:0];
        end
    end

    assign o_done = r_done;

    `LIF_ASSERT_NEXT(a_mul_start_busy, i_clk, i_rst_n, i_start, r_busy)
    `LIF_ASSERT_IMPL(a_mul_done_idle, i_clk, i_rst_n, o_done, !r_busy)
    `LIF_ASSERT_NEXT(a_mul_last_done, i_clk, i_rst_n, r_busy && !i_start && r_cnt == 5'd31, o_done)

endmodule

`default_nettype wire

@@ rtl/core/lif_neuron_store.sv @@
// Neuron state memory with a clearing pass after reset: one write port,
// one registered read port. Uses lif_pkg.
`default_nettype none

module lif_neuron_store
    import lif_pkg::*;
#(
    parameter int NEURONS = NEURONS_DEF,
    localparam int NAW = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [NAW-1:0] i_rd_addr,
    output t_neuron             o_rd_data,
    input  wire logic           i_wr_en,
    input  wire logic [NAW-1:0] i_wr_addr,
    input  wire t_neuron        i_wr_data,
    output logic                o_clearing
);

`include "lif_neuron_update_engine_assert.svh"

    localparam logic [NAW-1:0] LAST = NAW'(NEURONS - 1);

    t_neuron        r_mem [NEURONS];
    t_neuron        r_rd_data;
    logic           r_clr_active;
    logic [NAW-1:0] r_clr_idx;

    // Clearing pass: one entry per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clr_active) begin
            r_clr_idx <= r_clr_idx + NAW'(1);
            if (r_clr_idx == LAST) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // Memory array.
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_idx] <= NEURON_RESET;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr_active;

    `LIF_ASSERT_IMPL(a_st_no_wr_clear, i_clk, i_rst_n, r_clr_active, !i_wr_en)
    `LIF_ASSERT_NEXT(a_st_clear_end, i_clk, i_rst_n, r_clr_active && r_clr_idx == LAST, !r_clr_active)
    `LIF_ASSERT_NEXT(a_st_stay_done, i_clk, i_rst_n, !r_clr_active, !r_clr_active)

endmodule

`default_nettype wire

@@ rtl/core/lif_neuron_update_engine.sv @@
// Leaky integrate-and-fire neuron update engine, top level: command
// sequencer, population parameter memory, neuron store and serial multiplier.
// Every accepted command gives exactly one result beat, shown for one cycle
// on o_result under o_result_valid; the receiver cannot stall, so it must
// take it then. After reset the neuron store runs a clearing pass over all
// NEURONS entries with busy high. A parameter load, an opcode 3 or an
// out-of-range index reports in the cycle after the accept; an increment
// reads the neuron, adds the value to its synaptic current and writes it
// back; an update fetches the population parameters over the single read
// port of the parameter memory, then runs its three products (two when the
// neuron is refractory) one after another on the shared bit-serial multiplier.
`default_nettype none

module lif_neuron_update_engine
    import lif_pkg::*;
#(
    parameter int NEURONS     = NEURONS_DEF,
    parameter int POPULATIONS = POPULATIONS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_cmd i_cmd,
    output logic      o_result_valid,
    output t_result   o_result
);

`include "lif_neuron_update_engine_assert.svh"

    localparam int NAW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int PDEPTH = POPULATIONS * PARAM_SLOTS;
    localparam int PAW = $clog2(PDEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MUL_CUR,
        S_MUL_NOISE,
        S_DRIVE,
        S_MUL_MEM,
        S_CHECK,
        S_INC
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [3:0]         r_k;
    logic signed [31:0] r_p [PARAM_SLOTS];
    logic signed [31:0] r_pmem [PDEPTH];
    logic signed [31:0] r_prd;
    t_neuron            r_nw;
    logic signed [31:0] r_m1;
    logic signed [31:0] r_cur;
    logic signed [31:0] r_v;
    logic               r_inc_rd;
    logic               r_res_valid;
    t_result            r_res;

    logic               w_accept;
    logic               w_clearing;
    logic               w_n_ok;
    logic               w_p_ok;
    logic [PAW-1:0]     w_pwr_addr;
    logic [PAW-1:0]     w_prd_addr;
    t_neuron            w_rd;
    logic               w_wr_en;
    t_neuron            w_wr_data;
    logic               w_mul_start;
    logic signed [31:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic               w_mul_done;
    logic signed [31:0] w_mul_q;
    logic               w_refr;
    logic               w_spike;
    logic signed [33:0] w_refr_end;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE) || w_clearing;
    assign w_n_ok   = 32'(i_cmd.neuron) < NEURONS;
    assign w_p_ok   = 32'(i_cmd.population) < POPULATIONS;

    // Population parameter memory: written on a load, read once per cycle.
    assign w_pwr_addr = PAW'({i_cmd.population, i_cmd.param_select});
    assign w_prd_addr = PAW'({r_cmd.population, r_k[2:0]});

    always_ff @(posedge i_clk) begin
        if (w_accept && i_cmd.opcode == OP_LOAD && w_p_ok) begin
            r_pmem[w_pwr_addr] <= i_cmd.value;
        end
        r_prd <= r_pmem[w_prd_addr];
    end

    lif_neuron_store #(
        .NEURONS(NEURONS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (NAW'(r_cmd.neuron)),
        .o_rd_data  (w_rd),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (NAW'(r_cmd.neuron)),
        .i_wr_data  (w_wr_data),
        .o_clearing (w_clearing)
    );

    lif_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_q     (w_mul_q)
    );

    // Refractory window and threshold test; the window end may be negative.
    assign w_refr_end = 34'(r_nw.last_tick) + 34'(r_p[PS_REFR]);
    assign w_refr     = r_nw.has_spiked && ($signed({2'b00, r_cmd.tick}) <= w_refr_end);
    assign w_spike    = r_v > r_p[PS_THRESH];

    // Multiplier operands and store write-back.
    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = r_p[PS_KS];
        w_mul_b     = r_cmd.noise;
        w_wr_en     = 1'b0;
        w_wr_data   = r_nw;
        unique case (r_state)
            S_FETCH: begin
                w_mul_start = (r_k == 4'd8);
                w_mul_a     = r_p[PS_KS];
                w_mul_b     = sat32(34'(r_p[PS_MEAN]) - 34'(w_rd.syn_current));
            end
            S_MUL_CUR: begin
                w_mul_start = w_mul_done;
                w_mul_a     = r_p[PS_SIGMA];
                w_mul_b     = r_cmd.noise;
            end
            S_DRIVE: begin
                w_mul_start = !w_refr;
                w_mul_a     = r_p[PS_KM];
                w_mul_b     = sat32(34'(r_p[PS_REST]) - 34'(r_nw.membrane) + 34'(r_cur));
            end
            S_CHECK: begin
                w_wr_en                 = 1'b1;
                w_wr_data.syn_current   = r_cur;
                w_wr_data.membrane      = w_spike ? r_p[PS_RESET] : r_v;
                w_wr_data.last_tick     = w_spike ? r_cmd.tick : r_nw.last_tick;
                w_wr_data.has_spiked    = r_nw.has_spiked || w_spike;
            end
            S_INC: begin
                w_wr_en               = r_inc_rd;
                w_wr_data             = w_rd;
                w_wr_data.syn_current = sat32(34'(w_rd.syn_current) + 34'(r_cmd.value));
            end
            default: begin
            end
        endcase
    end

    // Command sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_k         <= '0;
            r_inc_rd    <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd <= i_cmd;
                        r_k   <= '0;
                        r_res <= '{spike: 1'b0, spike_neuron: i_cmd.neuron,
                                   spike_tick: 32'd0};
                        if (i_cmd.opcode == OP_UPDATE && w_n_ok && w_p_ok) begin
                            r_state <= S_FETCH;
                        end else if (i_cmd.opcode == OP_INC && w_n_ok) begin
                            r_inc_rd <= 1'b0;
                            r_state  <= S_INC;
                        end else begin
                            r_res_valid <= 1'b1;
                        end
                    end
                end
                S_FETCH: begin
                    r_k <= r_k + 4'd1;
                    if (r_k != 4'd0) begin
                        r_p[3'(r_k - 4'd1)] <= r_prd;
                    end
                    if (r_k == 4'd8) begin
                        r_nw    <= w_rd;
                        r_state <= S_MUL_CUR;
                    end
                end
                S_MUL_CUR: begin
                    if (w_mul_done) begin
                        r_m1    <= w_mul_q;
                        r_state <= S_MUL_NOISE;
                    end
                end
                S_MUL_NOISE: begin
                    if (w_mul_done) begin
                        r_cur   <= sat32(34'(r_nw.syn_current) + 34'(r_m1) + 34'(w_mul_q));
                        r_state <= S_DRIVE;
                    end
                end
                S_DRIVE: begin
                    r_v <= r_nw.membrane;
                    if (w_refr) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= S_MUL_MEM;
                    end
                end
                S_MUL_MEM: begin
                    if (w_mul_done) begin
                        r_v     <= sat32(34'(r_v) + 34'(w_mul_q));
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_res.spike      <= w_spike;
                    r_res.spike_tick <= w_spike ? r_cmd.tick : 32'd0;
                    r_res_valid      <= 1'b1;
                    r_state          <= S_IDLE;
                end
                S_INC: begin
                    r_inc_rd <= 1'b1;
                    if (r_inc_rd) begin
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    `LIF_ASSERT_IMPL(a_top_clear_busy, i_clk, i_rst_n, w_clearing, busy)
    `LIF_ASSERT_IMPL(a_top_quiet_tick, i_clk, i_rst_n, o_result_valid && !o_result.spike, o_result.spike_tick == 32'd0)
    `LIF_ASSERT_NEXT(a_top_update_go, i_clk, i_rst_n, w_accept && i_cmd.opcode == OP_UPDATE && w_n_ok && w_p_ok, r_state == S_FETCH)
    `LIF_ASSERT_IMPL(a_top_mul_idle, i_clk, i_rst_n, r_state == S_IDLE, !w_mul_done)

endmodule

`default_nettype wire
